// File: hw/rtl/kmspt_pkg.sv
// ----------------------------------------------------------------------------
// kmspt_pkg
// Shared types and constants for the key matrix scanner and press timer.
// ----------------------------------------------------------------------------
package kmspt_pkg;

    localparam int MODE_W = 1;
    localparam int COL_W  = 3;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;
    localparam int ROW_W  = 2;
    localparam int KEY_W  = 4;
    localparam int MAP_W  = 9;

    localparam logic [MODE_W-1:0] MODE_SCAN = 1'b0;
    localparam logic [MODE_W-1:0] MODE_POLL = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROW     = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COL_W-1:0]  column_levels;
        logic [TIME_W-1:0] now_ms;
    } t_in_req;

    typedef struct packed {
        t_kind             kind;
        logic [ROW_W-1:0]  row_select;
        logic [KEY_W-1:0]  key_number;
        logic [TIME_W-1:0] press_duration;
        logic [TIME_W-1:0] press_start;
        logic [MAP_W-1:0]  pressed_map;
        logic              last;
    } t_out_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_STATUS
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic upd_row;     // merge column sample, advance row
        logic latch_now;   // capture poll time, clear key index
        logic rec_press;   // store press time of current key
        logic walk_step;   // advance key index
        logic load_scan;
        logic load_event;
        logic load_status; // also commits reported map
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic changed;
        logic key_press;
        logic key_release;
        logic walk_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hw/rtl/key_matrix_scan_press_timer_core.sv
// Scan item: row-drive result registered from the scan state once the output is free;
//   next item accepted back in idle. Poll item: walk steps one key per cycle over
//   ROWS*COLS keys, held while a release waits on the output, then a status result.
// Poll with no map change: returns straight to idle, no results.
// Reset clears row, key maps, sequencer and output valid; press times are not cleared.
// ----------------------------------------------------------------------------
// key_matrix_scan_press_timer_core
// Key matrix scanner with per-key press timing and release events.
// ----------------------------------------------------------------------------
module key_matrix_scan_press_timer_core #(
    parameter int ROWS = 3,
    parameter int COLS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kmspt_pkg::t_in_req  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kmspt_pkg::t_out_req o_out
);

    kmspt_pkg::t_dp_cmd cmd;
    kmspt_pkg::t_dp_sts sts;

    kmspt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in.mode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    kmspt_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: hw/rtl/kmspt_ctrl.sv
// ----------------------------------------------------------------------------
// kmspt_ctrl
// Sequencer: scan handling, key walk on polls and result emission.
// ----------------------------------------------------------------------------
module kmspt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_mode,
    input  kmspt_pkg::t_dp_sts i_sts,
    output logic               o_in_stall,
    output kmspt_pkg::t_dp_cmd o_cmd
);

    kmspt_pkg::t_state r_state;
    kmspt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmspt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            kmspt_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_mode == kmspt_pkg::MODE_SCAN) begin
                        o_cmd.upd_row = 1'b1;
                        n_state       = kmspt_pkg::ST_SCAN;
                    end else begin
                        o_cmd.latch_now = 1'b1;
                        // no change since last report: poll yields nothing
                        n_state = i_sts.changed ? kmspt_pkg::ST_WALK : kmspt_pkg::ST_IDLE;
                    end
                end
            end
            kmspt_pkg::ST_SCAN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_scan = 1'b1;
                    n_state         = kmspt_pkg::ST_IDLE;
                end
            end
            kmspt_pkg::ST_WALK: begin
                if (i_sts.key_release) begin
                    if (i_sts.out_free) begin
                        o_cmd.load_event = 1'b1;
                        o_cmd.walk_step  = 1'b1;
                    end
                end else begin
                    o_cmd.rec_press = i_sts.key_press;
                    o_cmd.walk_step = 1'b1;
                end
                if (o_cmd.walk_step && i_sts.walk_done) begin
                    n_state = kmspt_pkg::ST_STATUS;
                end
            end
            kmspt_pkg::ST_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.load_status = 1'b1;
                    n_state           = kmspt_pkg::ST_IDLE;
                end
            end
            default: n_state = kmspt_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/kmspt_dp.sv
// ----------------------------------------------------------------------------
// kmspt_dp
// Datapath: key maps, row counter, press-time store and output register.
// ----------------------------------------------------------------------------
module kmspt_dp #(
    parameter int ROWS = 3,
    parameter int COLS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kmspt_pkg::t_in_req   i_in,
    input  kmspt_pkg::t_dp_cmd   i_cmd,
    input  logic                 i_out_stall,
    output kmspt_pkg::t_dp_sts   o_sts,
    output logic                 o_out_valid,
    output kmspt_pkg::t_out_req  o_out
);

    localparam int NKEYS  = ROWS * COLS;
    localparam int IDX_W  = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam int ROW_W  = kmspt_pkg::ROW_W;
    localparam int COL_W  = kmspt_pkg::COL_W;
    localparam int TIME_W = kmspt_pkg::TIME_W;
    localparam int KEY_W  = kmspt_pkg::KEY_W;
    localparam int MAP_W  = kmspt_pkg::MAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NKEYS - 1);

    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [NKEYS-1:0]  r_live;
    logic [NKEYS-1:0]  n_live;
    logic [NKEYS-1:0]  r_rep;
    logic [TIME_W-1:0] r_now;
    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_press_time [NKEYS];
    logic              r_out_valid;
    kmspt_pkg::t_out_req r_out;
    kmspt_pkg::t_out_req n_out;

    logic [ROW_W:0]        row_p1;
    logic [COLS+COL_W-1:0] pressed_ext;
    logic [IDX_W:0]        key_p1;
    logic [TIME_W-1:0]     start_ms;
    logic                  act;
    logic                  prev;

    // columns beyond the sample field read as released
    assign pressed_ext = {{COLS{1'b0}}, ~i_in.column_levels};
    assign row_p1      = {1'b0, r_row} + 1'b1;
    assign n_row       = (int'(row_p1) >= ROWS) ? '0 : row_p1[ROW_W-1:0];

    always_comb begin
        n_live = r_live;
        for (int r = 0; r < ROWS; r++) begin
            if (r_row == ROW_W'(r)) begin
                for (int c = 0; c < COLS; c++) begin
                    n_live[r*COLS + c] = pressed_ext[c];
                end
            end
        end
    end

    assign act      = r_live[r_idx];
    assign prev     = r_rep[r_idx];
    assign start_ms = r_press_time[r_idx];
    assign key_p1   = {1'b0, r_idx} + 1'b1;

    assign o_sts.changed     = (r_live != r_rep);
    assign o_sts.key_press   = act && !prev;
    assign o_sts.key_release = !act && prev;
    assign o_sts.walk_done   = (r_idx == LAST_IDX);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_live <= '0;
            r_rep  <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.upd_row) begin
                r_live <= n_live;
                r_row  <= n_row;
            end
            if (i_cmd.latch_now) begin
                r_idx <= '0;
            end else if (i_cmd.walk_step && r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load_status) begin
                r_rep <= r_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_now) begin
            r_now <= i_in.now_ms;
        end
        if (i_cmd.rec_press) begin
            r_press_time[r_idx] <= r_now;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_scan || i_cmd.load_event || i_cmd.load_status) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out = '0;
        if (i_cmd.load_scan) begin
            n_out.kind       = kmspt_pkg::KIND_ROW;
            n_out.row_select = r_row;
            n_out.last       = 1'b1;
        end else if (i_cmd.load_event) begin
            n_out.kind           = kmspt_pkg::KIND_RELEASE;
            n_out.key_number     = KEY_W'(key_p1);
            n_out.press_duration = r_now - start_ms;
            n_out.press_start    = start_ms;
        end else begin
            n_out.kind        = kmspt_pkg::KIND_STATUS;
            n_out.pressed_map = MAP_W'(r_live);
            n_out.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_scan || i_cmd.load_event || i_cmd.load_status) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: tb/sv/key_matrix_scan_press_timer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scan_press_timer_core_tb
// Sends scan ticks and report polls to the key matrix scanner. A local copy
// of the row, key map and press time state predicts every row drive, release
// event and status word. Results are checked in order while both sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module key_matrix_scan_press_timer_core_tb;

    localparam int ROW_W  = kmspt_pkg::ROW_W;
    localparam int COL_W  = kmspt_pkg::COL_W;
    localparam int TIME_W = kmspt_pkg::TIME_W;
    localparam int KEY_W  = kmspt_pkg::KEY_W;
    localparam int MAP_W  = kmspt_pkg::MAP_W;

    localparam int ROW_COUNT    = 3;
    localparam int COL_COUNT    = 3;
    localparam int KEY_COUNT    = ROW_COUNT * COL_COUNT;
    localparam int RANDOM_REQS  = 240;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    kmspt_pkg::t_in_req  req       = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    kmspt_pkg::t_out_req res;

    // predicted scanner state
    logic [ROW_W-1:0]    scan_row;
    logic [MAP_W-1:0]    live_keys;
    logic [MAP_W-1:0]    reported_keys;
    logic [TIME_W-1:0]   press_ms [KEY_COUNT];
    kmspt_pkg::t_out_req expected_key_results [$];

    int                error_count  = 0;
    int                cycle_count  = 0;
    int                produced_now = 0;
    bit                steady       = 1'b0;  // no idling on either side
    logic [TIME_W-1:0] clock_ms     = '0;

    key_matrix_scan_press_timer_core #(
        .ROWS(ROW_COUNT),
        .COLS(COL_COUNT)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in       (req),
        .o_out_valid(res_valid),
        .i_out_stall(res_stall),
        .o_out      (res)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_idle();
        int roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic kmspt_pkg::t_in_req make_scan(input logic [COL_W-1:0] levels);
        kmspt_pkg::t_in_req r;
        r               = '0;
        r.mode          = kmspt_pkg::MODE_SCAN;
        r.column_levels = levels;
        return r;
    endfunction

    function automatic kmspt_pkg::t_in_req make_poll(input logic [TIME_W-1:0] now);
        kmspt_pkg::t_in_req r;
        r        = '0;
        r.mode   = kmspt_pkg::MODE_POLL;
        r.now_ms = now;
        return r;
    endfunction

    // returns the number of results this request yields
    function automatic int predict_key_events(input kmspt_pkg::t_in_req r);
        kmspt_pkg::t_out_req item;
        int                  produced;
        logic                held;
        logic                was_held;
        produced = 0;
        if (r.mode == kmspt_pkg::MODE_SCAN) begin
            // column reads low when its key is down
            for (int c = 0; c < COL_COUNT; c++) begin
                live_keys[scan_row * COL_COUNT + c] = ~r.column_levels[c];
            end
            scan_row        = (scan_row == ROW_COUNT - 1) ? '0 : scan_row + 1'b1;
            item            = '0;
            item.kind       = kmspt_pkg::KIND_ROW;
            item.row_select = scan_row;
            item.last       = 1'b1;
            expected_key_results.push_back(item);
            return 1;
        end
        if (live_keys == reported_keys) begin
            return 0;
        end
        for (int k = 0; k < KEY_COUNT; k++) begin
            held     = live_keys[k];
            was_held = reported_keys[k];
            if (held && !was_held) begin
                press_ms[k] = r.now_ms;
            end else if (!held && was_held) begin
                item                = '0;
                item.kind           = kmspt_pkg::KIND_RELEASE;
                item.key_number     = KEY_W'(k + 1);
                item.press_start    = press_ms[k];
                item.press_duration = r.now_ms - press_ms[k];
                expected_key_results.push_back(item);
                produced++;
            end
        end
        item             = '0;
        item.kind        = kmspt_pkg::KIND_STATUS;
        item.pressed_map = live_keys;
        item.last        = 1'b1;
        expected_key_results.push_back(item);
        reported_keys = live_keys;
        return produced + 1;
    endfunction

    // valid stays up across back-to-back requests
    task automatic send_request(input kmspt_pkg::t_in_req r);
        int idle;
        idle = pick_idle();
        if (idle > 0) begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        produced_now = predict_key_events(r);
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // polls with nothing changed give no result
    task automatic test_quiet_polls();
        send_request(make_poll('0));
        send_request(make_poll('1));
    endtask

    // every column pattern, row wraps twice
    task automatic test_scan_patterns();
        for (int p = 0; p < 8; p++) begin
            send_request(make_scan(COL_W'(p)));
        end
        send_request(make_poll(32'h1234_5678));
    endtask

    // all keys down, then all up with the release time wrapped past zero
    task automatic test_full_press_release();
        steady = 1'b1;
        repeat (ROW_COUNT) send_request(make_scan('0));
        send_request(make_poll(32'hFFFF_FFF0));
        send_request(make_poll(32'hFFFF_FFF8));
        repeat (ROW_COUNT) send_request(make_scan('1));
        send_request(make_poll(32'h0000_0020));
        steady = 1'b0;
    endtask

    task automatic test_random_activity();
        int               counted;
        int               roll;
        logic [COL_W-1:0] levels;
        counted = 0;
        while (counted < RANDOM_REQS) begin
            if ($urandom_range(0, 19) == 0) begin
                steady = ~steady;
            end
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
                // full sweep of the matrix, then a report
                for (int k = 0; k < ROW_COUNT; k++) begin
                    for (int c = 0; c < COL_W; c++) begin
                        levels[c] = ($urandom_range(0, 3) != 0);
                    end
                    send_request(make_scan(levels));
                    counted++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    clock_ms = $urandom();
                end else begin
                    clock_ms = clock_ms + $urandom_range(1, 800);
                end
                send_request(make_poll(clock_ms));
                counted++;
            end else if (roll == 7) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(make_scan(COL_W'($urandom_range(0, 7))));
                    counted++;
                end
            end else begin
                send_request(make_poll($urandom()));
                counted++;
            end
        end
        steady = 1'b0;
    endtask

    initial begin : result_checker
        int                  stall_left;
        kmspt_pkg::t_out_req want;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall) begin
                if (expected_key_results.size() == 0) begin
                    error_count++;
                    $display({"%0t: unexpected result, expected none ",
                              "actual kind %0d key %0d map %03h"},
                             $time, res.kind, res.key_number, res.pressed_map);
                end else begin
                    want = expected_key_results.pop_front();
                    check_field("kind", TIME_W'(want.kind), TIME_W'(res.kind));
                    check_field("row_select", TIME_W'(want.row_select),
                                TIME_W'(res.row_select));
                    check_field("key_number", TIME_W'(want.key_number),
                                TIME_W'(res.key_number));
                    check_field("press_duration", want.press_duration, res.press_duration);
                    check_field("press_start", want.press_start, res.press_start);
                    check_field("pressed_map", TIME_W'(want.pressed_map),
                                TIME_W'(res.pressed_map));
                    check_field("last", TIME_W'(want.last), TIME_W'(res.last));
                end
            end
            if (stall_left == 0) begin
                stall_left = pick_idle();
            end
            res_stall <= (stall_left > 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("key_matrix_scan_press_timer_core verification failed");
        $finish;
    end

    initial begin : main_sequence
        scan_row      = '0;
        live_keys     = '0;
        reported_keys = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_quiet_polls();
        test_scan_patterns();
        test_full_press_release();
        test_random_activity();

        req_valid <= 1'b0;
        while (expected_key_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("key_matrix_scan_press_timer_core verification clean");
        end else begin
            $display("key_matrix_scan_press_timer_core verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/kmspt_pkg.sv
hw/rtl/kmspt_ctrl.sv
hw/rtl/kmspt_dp.sv
hw/rtl/key_matrix_scan_press_timer_core.sv
tb/sv/key_matrix_scan_press_timer_core_tb.sv
